// ===== design/mbt_pkg.sv =====
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the perceptron trainer
// Op codes, register indexes, sequencer types, the sigmoid table and the
// rounding and saturation helpers used across the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

    localparam int MAC_AW = 36;   // multiplier operand A
    localparam int MAC_BW = 16;   // multiplier operand B
    localparam int MAC_PW = MAC_AW + MAC_BW;
    localparam int ACC_W  = 56;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_LOAD  = 3'd2;
    localparam logic [2:0] OP_TRAIN = 3'd3;
    localparam logic [2:0] OP_INFER = 3'd4;

    localparam logic [1:0] CFG_LEARN_RATE  = 2'd0;
    localparam logic [1:0] CFG_BATCH_USED  = 2'd1;
    localparam logic [1:0] CFG_HIDDEN_USED = 2'd2;

    localparam logic [14:0] LR_RESET = 15'd3277;
    localparam logic [2:0]  BU_RESET = 3'd4;
    localparam logic [4:0]  HU_RESET = 5'd16;

    localparam logic signed [15:0] Q_ONE  = 16'sd4096;
    localparam logic [12:0]        T_MAX  = 13'd4096;

    typedef struct packed {
        logic go;
        logic clr;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA,
        ST_WAIT,
        ST_POST,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        PH_RD,
        PH_HID,
        PH_OUT,
        PH_YD,
        PH_DY,
        PH_HD,
        PH_P1,
        PH_DH,
        PH_G,
        PH_UPD
    } t_phase;

    typedef enum logic [1:0] {
        GRP_OW,
        GRP_OB,
        GRP_HW,
        GRP_HB
    } t_grp;

    // round(4096 * sigmoid(x)) at x = 0, 0.5, ..., 8
    function automatic logic [12:0] sig_tab(input logic [4:0] idx);
        logic [12:0] v;
        unique case (idx)
            5'd0:    v = 13'd2048;
            5'd1:    v = 13'd2550;
            5'd2:    v = 13'd2994;
            5'd3:    v = 13'd3349;
            5'd4:    v = 13'd3608;
            5'd5:    v = 13'd3785;
            5'd6:    v = 13'd3902;
            5'd7:    v = 13'd3976;
            5'd8:    v = 13'd4022;
            5'd9:    v = 13'd4051;
            5'd10:   v = 13'd4069;
            5'd11:   v = 13'd4079;
            5'd12:   v = 13'd4086;
            5'd13:   v = 13'd4090;
            5'd14:   v = 13'd4092;
            5'd15:   v = 13'd4094;
            default: v = 13'd4095;
        endcase
        return v;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic logic signed [ACC_W-1:0] round_sh(input logic signed [ACC_W-1:0] v,
                                                         input logic [4:0] s);
        logic signed [ACC_W-1:0] half;
        half = ACC_W'(1) <<< (s - 5'd1);
        return (v + half) >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mbt_mac.sv =====
// ----------------------------------------------------------------------------
// mbt_mac: shared multiply-accumulate unit
// One signed multiply per cycle into a product register, then accumulate;
// a clear flag travels with the product and starts a fresh sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_mac (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire mbt_pkg::t_mac_ctl                    i_ctl,
    input  wire logic signed [mbt_pkg::MAC_AW-1:0]    i_a,
    input  wire logic signed [mbt_pkg::MAC_BW-1:0]    i_b,
    output logic signed      [mbt_pkg::ACC_W-1:0]     o_acc
);
    import mbt_pkg::*;

    logic signed [MAC_PW-1:0] r_prod;
    logic signed [MAC_PW-1:0] s_ae;
    logic signed [MAC_PW-1:0] s_be;
    logic                     r_pv;
    logic                     r_pclr;
    logic signed [ACC_W-1:0]  r_acc;

    assign s_ae  = MAC_PW'(i_a);
    assign s_be  = MAC_PW'(i_b);
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv   <= 1'b0;
            r_pclr <= 1'b0;
        end else begin
            r_pv   <= i_ctl.go;
            r_pclr <= i_ctl.clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= s_ae * s_be;
        if (r_pv) begin
            r_acc <= (r_pclr ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

endmodule

`default_nettype wire

// ===== design/mbt_sigmoid.sv =====
// ----------------------------------------------------------------------------
// mbt_sigmoid: table sigmoid with linear interpolation
// Q4.12 in, Q0.12 out; the table covers |x| up to 8, negative x mirrors.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_sigmoid (
    input  wire logic signed [15:0] i_z,
    output logic             [12:0] o_y
);
    import mbt_pkg::*;

    logic signed [16:0] s_ze;
    logic        [16:0] s_m;
    logic        [5:0]  s_idx;
    logic        [10:0] s_frac;
    logic        [12:0] s_base;
    logic        [12:0] s_next;
    logic        [23:0] s_prod;
    logic        [12:0] s_r;

    assign s_ze   = {i_z[15], i_z};
    assign s_m    = i_z[15] ? 17'(-s_ze) : 17'(s_ze);
    assign s_idx  = s_m[16:11];
    assign s_frac = s_m[10:0];
    assign s_base = sig_tab(s_idx[4:0]);
    assign s_next = sig_tab(s_idx[4:0] + 5'd1);
    assign s_prod = 24'(s_next - s_base) * 24'(s_frac);

    always_comb begin
        if (s_idx >= 6'd16) begin
            s_r = sig_tab(5'd16);
        end else begin
            s_r = s_base + 13'(s_prod >> 11);
        end
    end

    assign o_y = i_z[15] ? (T_MAX - s_r) : s_r;

endmodule

`default_nettype wire

// ===== design/mlp_backprop_trainer.sv =====
// ----------------------------------------------------------------------------
// mlp_backprop_trainer: two-layer sigmoid perceptron with batch training
// Sequencer, parameter and scratch memories around one shared MAC unit.
// ----------------------------------------------------------------------------
// One word in, one word out, one word at a time. Write, load and bad or
// unknown ops go straight to the result register; a parameter read passes
// the parameter memory first. Every product term passes the single
// multiplier through its product register and the accumulator, so the
// length of an infer grows with hu hidden neurons and that of an epoch
// with hu and with bu samples in use. The shared multiplier sets the
// length of both. Parameters and samples read back only what was
// written before.
`default_nettype none

module mlp_backprop_trainer #(
    parameter int HIDDEN = 16,
    parameter int INPUTS = 2,
    parameter int BATCH  = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [14:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_op,
    input  wire logic [6:0]         i_index,
    input  wire logic signed [15:0] i_value,
    input  wire logic signed [15:0] i_feature_a,
    input  wire logic signed [15:0] i_feature_b,
    input  wire logic [12:0]        i_target,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_data,
    output logic                    o_bad_index
);
    import mbt_pkg::*;

    localparam int NPARAM = INPUTS * HIDDEN + 2 * HIDDEN + 1;
    localparam int PA     = $clog2(NPARAM);
    localparam int NS     = BATCH * HIDDEN;
    localparam int SA     = (NS > 1) ? $clog2(NS) : 1;
    localparam int KC     = $clog2(BATCH + 1);
    localparam int KW     = (BATCH > 1) ? $clog2(BATCH) : 1;
    localparam int JC     = $clog2(HIDDEN + 1);
    localparam int IC     = $clog2(INPUTS + 1);
    localparam int TM1    = (HIDDEN > INPUTS) ? HIDDEN : INPUTS;
    localparam int TMAX   = (TM1 > BATCH) ? TM1 : BATCH;
    localparam int TC     = $clog2(TMAX + 1);

    // control
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_grp   r_grp,   n_grp;
    logic [KC-1:0] r_k, n_k;
    logic [JC-1:0] r_j, n_j;
    logic [IC-1:0] r_i, n_i;
    logic [TC-1:0] r_t, n_t;
    logic          r_ov;

    // datapath
    logic [2:0]         r_op, n_op;
    logic signed [15:0] r_fa, n_fa;
    logic signed [15:0] r_fb, n_fb;
    logic signed [15:0] r_res, n_res;
    logic               r_rbad, n_rbad;
    logic [PA-1:0]      r_pa, n_pa;
    logic [12:0]        r_y, n_y;
    logic signed [15:0] r_yd, n_yd;
    logic signed [15:0] r_hd, n_hd;
    logic signed [MAC_AW-1:0] r_p1, n_p1;
    logic signed [MAC_AW-1:0] r_g, n_g;
    logic signed [15:0] r_odata;
    logic               r_obad;

    logic [14:0] r_lr;
    logic [2:0]  r_bu;
    logic [4:0]  r_hu;

    // stores
    logic signed [15:0] r_pmem [NPARAM];
    logic signed [15:0] r_hmem [NS];
    logic signed [15:0] r_dmem [NS];
    logic signed [15:0] r_prd;
    logic signed [15:0] r_hrd;
    logic signed [15:0] r_drd;
    logic signed [15:0] r_dy [BATCH];
    logic signed [15:0] r_sa [BATCH];
    logic signed [15:0] r_sb [BATCH];
    logic [12:0]        r_st [BATCH];

    // combinational
    logic               s_acc;
    logic               s_pbad;
    logic               s_sbad;
    logic [JC-1:0]      s_hu;
    logic [KC-1:0]      s_bu;
    logic               s_last;
    logic [KC-1:0]      s_kx;
    logic [KC-1:0]      s_kk;
    logic [JC-1:0]      s_jj;
    logic [SA-1:0]      s_saddr;
    logic [PA-1:0]      s_upa;
    logic [PA-1:0]      s_paddr;
    logic               s_pwe;
    logic [PA-1:0]      s_pwaddr;
    logic signed [15:0] s_pwdata;
    logic               s_hwe;
    logic               s_dwe;
    logic               s_dywe;
    logic               s_swe;
    logic [IC-1:0]      s_xi;
    logic signed [15:0] s_xa;
    logic signed [15:0] s_xb;
    logic signed [15:0] s_x;
    t_mac_ctl           s_mac;
    logic signed [MAC_AW-1:0] s_a;
    logic signed [MAC_BW-1:0] s_b;
    logic signed [ACC_W-1:0]  s_accv;
    logic signed [15:0] s_pre;
    logic [12:0]        s_sig;
    logic signed [ACC_W-1:0]  s_r12;
    logic signed [ACC_W-1:0]  s_r24;
    logic signed [15:0] s_newp;

    mbt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_mac),
        .i_a     (s_a),
        .i_b     (s_b),
        .o_acc   (s_accv)
    );

    mbt_sigmoid u_sig (
        .i_z (s_pre),
        .o_y (s_sig)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign s_acc       = i_valid && (r_state == ST_IDLE);
    assign s_pbad      = {4'b0, i_index} >= 11'(NPARAM);
    assign s_sbad      = {1'b0, i_index} >= 8'(BATCH);
    assign o_valid     = r_ov;
    assign o_data      = r_odata;
    assign o_bad_index = r_obad;

    assign s_r12  = round_sh(s_accv, 5'd12);
    assign s_r24  = round_sh(s_accv, 5'd24);
    assign s_pre  = sat16(s_r12);
    assign s_newp = sat16(ACC_W'(r_prd) + s_r24);

    // effective counts
    always_comb begin
        if (r_hu == 5'd0) begin
            s_hu = JC'(1);
        end else if ({3'b0, r_hu} > 8'(HIDDEN)) begin
            s_hu = JC'(HIDDEN);
        end else begin
            s_hu = JC'(r_hu);
        end
        if (r_bu == 3'd0) begin
            s_bu = KC'(1);
        end else if ({5'b0, r_bu} > 8'(BATCH)) begin
            s_bu = KC'(BATCH);
        end else begin
            s_bu = KC'(r_bu);
        end
    end

    // sample and neuron addressing
    assign s_kx    = (r_phase == PH_G) ? KC'(r_t) : r_k;
    assign s_kk    = s_kx;
    assign s_jj    = (r_phase == PH_OUT) ? JC'(r_t - TC'(1)) : r_j;
    assign s_saddr = SA'(s_kk * HIDDEN + s_jj);
    assign s_xa    = (r_op == OP_INFER) ? r_fa : r_sa[s_kx[KW-1:0]];
    assign s_xb    = (r_op == OP_INFER) ? r_fb : r_sb[s_kx[KW-1:0]];
    assign s_xi    = (r_phase == PH_G) ? r_i : IC'(r_t - TC'(1));

    always_comb begin
        if (s_xi == IC'(0)) begin
            s_x = s_xa;
        end else if (s_xi == IC'(1)) begin
            s_x = s_xb;
        end else begin
            s_x = '0;
        end
    end

    always_comb begin
        unique case (r_grp)
            GRP_OW:  s_upa = PA'(INPUTS * HIDDEN + HIDDEN + r_j);
            GRP_OB:  s_upa = PA'(NPARAM - 1);
            GRP_HW:  s_upa = PA'(r_i * HIDDEN + r_j);
            GRP_HB:  s_upa = PA'(INPUTS * HIDDEN + r_j);
            default: s_upa = '0;
        endcase
    end

    always_comb begin
        unique case (r_phase)
            PH_HID:  s_last = (r_t == TC'(INPUTS));
            PH_OUT:  s_last = (r_t == TC'(s_hu));
            PH_G:    s_last = (r_t == (TC'(s_bu) - TC'(1)));
            default: s_last = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_grp   = r_grp;
        n_k     = r_k;
        n_j     = r_j;
        n_i     = r_i;
        n_t     = r_t;
        n_op    = r_op;
        n_fa    = r_fa;
        n_fb    = r_fb;
        n_res   = r_res;
        n_rbad  = r_rbad;
        n_pa    = r_pa;
        n_y     = r_y;
        n_yd    = r_yd;
        n_hd    = r_hd;
        n_p1    = r_p1;
        n_g     = r_g;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_op    = i_op;
                    n_fa    = i_feature_a;
                    n_fb    = i_feature_b;
                    n_res   = '0;
                    n_rbad  = 1'b0;
                    n_k     = '0;
                    n_j     = '0;
                    n_i     = '0;
                    n_t     = '0;
                    n_state = ST_DONE;
                    if (i_op == OP_WRITE || i_op == OP_READ) begin
                        if (s_pbad) begin
                            n_rbad = 1'b1;
                        end else if (i_op == OP_READ) begin
                            n_pa    = PA'(i_index);
                            n_phase = PH_RD;
                            n_state = ST_ADDR;
                        end
                    end else if (i_op == OP_LOAD) begin
                        n_rbad = s_sbad;
                    end else if (i_op == OP_TRAIN || i_op == OP_INFER) begin
                        n_phase = PH_HID;
                        n_state = ST_ADDR;
                    end
                end
            end
            ST_ADDR: n_state = ST_DATA;
            ST_DATA: begin
                if (r_phase == PH_RD) begin
                    n_res   = r_prd;
                    n_state = ST_DONE;
                end else if (s_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_t     = r_t + TC'(1);
                    n_state = ST_ADDR;
                end
            end
            ST_WAIT: n_state = ST_POST;
            ST_POST: begin
                n_t     = '0;
                n_state = ST_ADDR;
                unique case (r_phase)
                    PH_HID: begin
                        if ((r_j + JC'(1)) < s_hu) begin
                            n_j = r_j + JC'(1);
                        end else begin
                            n_j     = '0;
                            n_phase = PH_OUT;
                        end
                    end
                    PH_OUT: begin
                        n_y = s_sig;
                        if (r_op == OP_INFER) begin
                            n_res   = 16'(s_sig);
                            n_state = ST_DONE;
                        end else begin
                            n_phase = PH_YD;
                        end
                    end
                    PH_YD: begin
                        n_yd    = s_r12[15:0];
                        n_phase = PH_DY;
                    end
                    PH_DY: begin
                        n_j     = '0;
                        n_phase = PH_HD;
                    end
                    PH_HD: begin
                        n_hd    = s_r12[15:0];
                        n_phase = PH_P1;
                    end
                    PH_P1: begin
                        n_p1    = s_accv[MAC_AW-1:0];
                        n_phase = PH_DH;
                    end
                    PH_DH: begin
                        if ((r_j + JC'(1)) < s_hu) begin
                            n_j     = r_j + JC'(1);
                            n_phase = PH_HD;
                        end else if ((r_k + KC'(1)) < s_bu) begin
                            n_k     = r_k + KC'(1);
                            n_j     = '0;
                            n_phase = PH_HID;
                        end else begin
                            n_j     = '0;
                            n_i     = '0;
                            n_grp   = GRP_OW;
                            n_phase = PH_G;
                        end
                    end
                    PH_G: begin
                        n_g     = s_accv[MAC_AW-1:0];
                        n_phase = PH_UPD;
                    end
                    PH_UPD: begin
                        n_phase = PH_G;
                        unique case (r_grp)
                            GRP_OW: begin
                                if ((r_j + JC'(1)) < s_hu) begin
                                    n_j = r_j + JC'(1);
                                end else begin
                                    n_j   = '0;
                                    n_grp = GRP_OB;
                                end
                            end
                            GRP_OB: begin
                                n_i   = '0;
                                n_j   = '0;
                                n_grp = GRP_HW;
                            end
                            GRP_HW: begin
                                if ((r_j + JC'(1)) < s_hu) begin
                                    n_j = r_j + JC'(1);
                                end else if ((r_i + IC'(1)) < IC'(INPUTS)) begin
                                    n_i = r_i + IC'(1);
                                    n_j = '0;
                                end else begin
                                    n_j   = '0;
                                    n_grp = GRP_HB;
                                end
                            end
                            default: begin
                                if ((r_j + JC'(1)) < s_hu) begin
                                    n_j = r_j + JC'(1);
                                end else begin
                                    n_state = ST_DONE;
                                end
                            end
                        endcase
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (!r_ov || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs: operands, addresses, write strobes
    always_comb begin
        s_mac.go  = (r_state == ST_DATA) && (r_phase != PH_RD);
        s_mac.clr = (r_t == TC'(0));
        s_a       = '0;
        s_b       = '0;
        s_paddr   = r_pa;
        unique case (r_phase)
            PH_HID: begin
                if (r_t == TC'(0)) begin
                    s_paddr = PA'(INPUTS * HIDDEN + r_j);
                    s_a     = MAC_AW'(r_prd);
                    s_b     = Q_ONE;
                end else begin
                    s_paddr = PA'((r_t - TC'(1)) * HIDDEN + r_j);
                    s_a     = MAC_AW'(s_x);
                    s_b     = r_prd;
                end
            end
            PH_OUT: begin
                if (r_t == TC'(0)) begin
                    s_paddr = PA'(NPARAM - 1);
                    s_a     = MAC_AW'(r_prd);
                    s_b     = Q_ONE;
                end else begin
                    s_paddr = PA'(INPUTS * HIDDEN + HIDDEN + s_jj);
                    s_a     = MAC_AW'(r_hrd);
                    s_b     = r_prd;
                end
            end
            PH_YD: begin
                s_a = MAC_AW'($signed({1'b0, r_y}));
                s_b = Q_ONE - $signed({3'b0, r_y});
            end
            PH_DY: begin
                s_a = MAC_AW'($signed({1'b0, r_st[s_kx[KW-1:0]]}) - $signed({1'b0, r_y}));
                s_b = r_yd;
            end
            PH_HD: begin
                s_a = MAC_AW'(r_hrd);
                s_b = Q_ONE - r_hrd;
            end
            PH_P1: begin
                s_paddr = PA'(INPUTS * HIDDEN + HIDDEN + r_j);
                s_a     = MAC_AW'(r_dy[s_kx[KW-1:0]]);
                s_b     = r_prd;
            end
            PH_DH: begin
                s_a = r_p1;
                s_b = r_hd;
            end
            PH_G: begin
                s_paddr = s_upa;
                unique case (r_grp)
                    GRP_OW: begin
                        s_a = MAC_AW'(r_hrd);
                        s_b = r_dy[s_kx[KW-1:0]];
                    end
                    GRP_OB: begin
                        s_a = MAC_AW'(r_dy[s_kx[KW-1:0]]);
                        s_b = Q_ONE;
                    end
                    GRP_HW: begin
                        s_a = MAC_AW'(r_drd);
                        s_b = s_x;
                    end
                    default: begin
                        s_a = MAC_AW'(r_drd);
                        s_b = Q_ONE;
                    end
                endcase
            end
            PH_UPD: begin
                s_paddr = s_upa;
                s_a     = r_g;
                s_b     = $signed({1'b0, r_lr});
            end
            default: s_paddr = r_pa;
        endcase

        s_pwe    = 1'b0;
        s_pwaddr = s_upa;
        s_pwdata = s_newp;
        if (r_state == ST_IDLE) begin
            s_pwe    = s_acc && (i_op == OP_WRITE) && !s_pbad;
            s_pwaddr = PA'(i_index);
            s_pwdata = i_value;
        end else if (r_state == ST_POST && r_phase == PH_UPD) begin
            s_pwe = 1'b1;
        end
        s_hwe  = (r_state == ST_POST) && (r_phase == PH_HID);
        s_dwe  = (r_state == ST_POST) && (r_phase == PH_DH);
        s_dywe = (r_state == ST_POST) && (r_phase == PH_DY);
        s_swe  = s_acc && (i_op == OP_LOAD) && !s_sbad;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (s_pwe) begin
            r_pmem[s_pwaddr] <= s_pwdata;
        end
        r_prd <= r_pmem[s_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_hwe) begin
            r_hmem[s_saddr] <= 16'(s_sig);
        end
        r_hrd <= r_hmem[s_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_dwe) begin
            r_dmem[s_saddr] <= s_r24[15:0];
        end
        r_drd <= r_dmem[s_saddr];
    end

    always_ff @(posedge i_clk) begin
        if (s_dywe) begin
            r_dy[s_kx[KW-1:0]] <= s_r12[15:0];
        end
        if (s_swe) begin
            r_sa[i_index[KW-1:0]] <= i_feature_a;
            r_sb[i_index[KW-1:0]] <= i_feature_b;
            r_st[i_index[KW-1:0]] <= (i_target > T_MAX) ? T_MAX : i_target;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_RD;
            r_grp   <= GRP_OW;
            r_k     <= '0;
            r_j     <= '0;
            r_i     <= '0;
            r_t     <= '0;
            r_ov    <= 1'b0;
            r_lr    <= LR_RESET;
            r_bu    <= BU_RESET;
            r_hu    <= HU_RESET;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_grp   <= n_grp;
            r_k     <= n_k;
            r_j     <= n_j;
            r_i     <= n_i;
            r_t     <= n_t;
            if (r_state == ST_DONE && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LEARN_RATE:  r_lr <= i_cfg_data;
                    CFG_BATCH_USED:  r_bu <= i_cfg_data[2:0];
                    CFG_HIDDEN_USED: r_hu <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_fa   <= n_fa;
        r_fb   <= n_fb;
        r_res  <= n_res;
        r_rbad <= n_rbad;
        r_pa   <= n_pa;
        r_y    <= n_y;
        r_yd   <= n_yd;
        r_hd   <= n_hd;
        r_p1   <= n_p1;
        r_g    <= n_g;
        if (r_state == ST_DONE && (!r_ov || !i_stall)) begin
            r_odata <= r_res;
            r_obad  <= r_rbad;
        end
    end

`ifndef SYNTHESIS
    a_long_op_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_op == OP_TRAIN || i_op == OP_INFER)) |=> (r_state == ST_ADDR))
        else $error("train or infer word did not start the sequencer");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_ov) |=> (o_valid && r_state == ST_IDLE))
        else $error("finished result not moved to the output register");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ov) |-> $past(!i_stall))
        else $error("output word dropped while stalled");

    a_neuron_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE && r_phase == PH_HID) |-> (r_j < s_hu))
        else $error("hidden neuron counter past the neurons in use");
`endif

endmodule

`default_nettype wire

// ===== verif/mlp_backprop_trainer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlp_backprop_trainer_tb: self-checking bench of the perceptron trainer
// Drives parameter writes and reads, sample loads, epochs and inferences with
// random idle and stall gaps on both channels. A behavioral network with its own
// weights and samples predicts each result word the directed rows leave open.
// Several learning rate, batch and hidden-size settings are applied between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_backprop_trainer_tb;
    import mbt_pkg::*;

    localparam int NHID     = 16;
    localparam int NBATCH   = 4;
    localparam int NPAR     = 65;
    localparam int IDX_HB   = 32;
    localparam int IDX_OW   = 48;
    localparam int IDX_OB   = 64;
    localparam int WD_LIMIT = 20000;
    localparam int N_DIR    = 22;
    localparam int N_PHASE  = 5;
    localparam int PER_PHASE = 116;

    typedef struct {
        logic [2:0]         op;
        logic [6:0]         idx;
        logic signed [15:0] val;
        logic signed [15:0] fa;
        logic signed [15:0] fb;
        logic [12:0]        tg;
    } t_word;

    typedef struct {
        logic signed [15:0] data;
        logic               bad;
    } t_reply;

    typedef struct {
        t_word  w;
        logic   typed;
        t_reply r;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [14:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_op;
    logic [6:0]         i_index;
    logic signed [15:0] i_value;
    logic signed [15:0] i_feature_a;
    logic signed [15:0] i_feature_b;
    logic [12:0]        i_target;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_data;
    logic               o_bad_index;

    mlp_backprop_trainer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_feature_a (i_feature_a),
        .i_feature_b (i_feature_b),
        .i_target    (i_target),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .o_bad_index (o_bad_index)
    );

    // network copy
    int hw [2*NHID];
    int hb [NHID];
    int ow [NHID];
    int ob;
    int smp_a [NBATCH];
    int smp_b [NBATCH];
    int smp_t [NBATCH];
    int hid_act [NBATCH*NHID];
    int hid_tmp [NHID];
    int lr, bu_reg, hu_reg;

    t_reply reply_q [$];
    int     errors = 0;
    int     wd_count = 0;
    logic   hold_req = 1'b0;

    const int SIG [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                           4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

    function automatic longint rnd_sh(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic int sat(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int sigmoid(int z);
        int m, k, r;
        m = (z < 0) ? -z : z;
        k = m >> 11;
        if (k >= 16) r = SIG[16];
        else r = SIG[k] + (((SIG[k+1] - SIG[k]) * (m & 2047)) >>> 11);
        return (z < 0) ? 4096 - r : r;
    endfunction

    function automatic int hid_n();
        if (hu_reg == 0) return 1;
        return (hu_reg > NHID) ? NHID : hu_reg;
    endfunction

    function automatic int batch_n();
        if (bu_reg == 0) return 1;
        return (bu_reg > NBATCH) ? NBATCH : bu_reg;
    endfunction

    // hidden outputs land in hid_tmp
    function automatic int net_output(int a, int b);
        longint acc;
        acc = 0;
        for (int j = 0; j < hid_n(); j++) begin
            acc = longint'(hb[j]) * 4096 + longint'(a) * hw[j] + longint'(b) * hw[NHID + j];
            hid_tmp[j] = sigmoid(sat(rnd_sh(acc, 12)));
        end
        acc = longint'(ob) * 4096;
        for (int j = 0; j < hid_n(); j++) acc += longint'(hid_tmp[j]) * ow[j];
        return sigmoid(sat(rnd_sh(acc, 12)));
    endfunction

    function automatic int stepped(int p, longint g);
        return sat(longint'(p) + rnd_sh(longint'(lr) * g, 24));
    endfunction

    function automatic void run_epoch();
        int     dy [NBATCH];
        int     dh [NBATCH*NHID];
        int     y, yd, hd, hu, bn;
        longint g, ga, gb;
        hu = hid_n();
        bn = batch_n();
        for (int k = 0; k < bn; k++) begin
            y  = net_output(smp_a[k], smp_b[k]);
            yd = int'(rnd_sh(longint'(y) * (4096 - y), 12));
            dy[k] = int'(rnd_sh(longint'(smp_t[k] - y) * yd, 12));
            for (int j = 0; j < hu; j++) begin
                hid_act[k*NHID + j] = hid_tmp[j];
                hd = int'(rnd_sh(longint'(hid_tmp[j]) * (4096 - hid_tmp[j]), 12));
                dh[k*NHID + j] = int'(rnd_sh(longint'(dy[k]) * ow[j] * hd, 24));
            end
        end
        for (int j = 0; j < hu; j++) begin
            g = 0;
            for (int k = 0; k < bn; k++) g += longint'(hid_act[k*NHID + j]) * dy[k];
            ow[j] = stepped(ow[j], g);
        end
        g = 0;
        for (int k = 0; k < bn; k++) g += longint'(dy[k]) * 4096;
        ob = stepped(ob, g);
        for (int j = 0; j < hu; j++) begin
            ga = 0;
            gb = 0;
            g  = 0;
            for (int k = 0; k < bn; k++) begin
                ga += longint'(smp_a[k]) * dh[k*NHID + j];
                gb += longint'(smp_b[k]) * dh[k*NHID + j];
                g  += longint'(dh[k*NHID + j]) * 4096;
            end
            hw[j]        = stepped(hw[j], ga);
            hw[NHID + j] = stepped(hw[NHID + j], gb);
            hb[j]        = stepped(hb[j], g);
        end
    endfunction

    function automatic t_reply predict_reply(t_word w);
        t_reply r;
        int     ix;
        r.data = '0;
        r.bad  = 1'b0;
        ix = int'(w.idx);
        case (w.op)
            OP_WRITE, OP_READ: begin
                if (ix >= NPAR) begin
                    r.bad = 1'b1;
                end else if (w.op == OP_WRITE) begin
                    if (ix < IDX_HB) hw[ix] = int'(w.val);
                    else if (ix < IDX_OW) hb[ix - IDX_HB] = int'(w.val);
                    else if (ix < IDX_OB) ow[ix - IDX_OW] = int'(w.val);
                    else ob = int'(w.val);
                end else begin
                    if (ix < IDX_HB) r.data = 16'(hw[ix]);
                    else if (ix < IDX_OW) r.data = 16'(hb[ix - IDX_HB]);
                    else if (ix < IDX_OB) r.data = 16'(ow[ix - IDX_OW]);
                    else r.data = 16'(ob);
                end
            end
            OP_LOAD: begin
                if (ix >= NBATCH) begin
                    r.bad = 1'b1;
                end else begin
                    smp_a[ix] = int'(w.fa);
                    smp_b[ix] = int'(w.fb);
                    smp_t[ix] = (w.tg > T_MAX) ? int'(T_MAX) : int'(w.tg);
                end
            end
            OP_TRAIN: run_epoch();
            OP_INFER: r.data = 16'(net_output(int'(w.fa), int'(w.fb)));
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] rand_q();
        if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 8192)) - 4096);
        return 16'($urandom);
    endfunction

    function automatic t_word rand_word();
        t_word w;
        int    r;
        r = $urandom_range(0, 99);
        w.val = rand_q();
        w.fa  = rand_q();
        w.fb  = rand_q();
        w.tg  = ($urandom_range(0, 4) != 0) ? 13'($urandom_range(0, 4096)) : 13'($urandom);
        w.idx = 7'($urandom);
        if (r < 25) w.op = OP_WRITE;
        else if (r < 45) w.op = OP_READ;
        else if (r < 60) w.op = OP_LOAD;
        else if (r < 72) w.op = OP_TRAIN;
        else if (r < 95) w.op = OP_INFER;
        else w.op = 3'($urandom_range(5, 7));
        if ((w.op == OP_WRITE || w.op == OP_READ) && $urandom_range(0, 9) != 0)
            w.idx = 7'($urandom_range(0, NPAR - 1));
        if (w.op == OP_LOAD && $urandom_range(0, 6) != 0)
            w.idx = 7'($urandom_range(0, NBATCH - 1));
        return w;
    endfunction

    // offer one word after a random gap, hold it until taken
    task automatic send_word(t_word w, logic typed, t_reply r_typed);
        int     r, gap;
        t_reply r_pred;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= w.op;
        i_index     <= w.idx;
        i_value     <= w.val;
        i_feature_a <= w.fa;
        i_feature_b <= w.fb;
        i_target    <= w.tg;
        do @(posedge i_clk); while (o_stall);
        r_pred = predict_reply(w);
        reply_q.push_back(typed ? r_typed : r_pred);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic cfg_write(logic [1:0] ix, int v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data  <= 15'(v);
        @(posedge i_clk);
        case (ix)
            CFG_LEARN_RATE:  lr = v & 32'h7FFF;
            CFG_BATCH_USED:  bu_reg = v & 7;
            CFG_HIDDEN_USED: hu_reg = v & 31;
            default: ;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern
    initial begin
        int   r, n;
        logic hold_done;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_stall <= 1'b0;
                    n = $urandom_range(1, 20);
                end else if (r < 90) begin
                    i_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_stall <= 1'b1;
                    n = $urandom_range(20, 60);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // compare each taken result word with the oldest prediction
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: data %0d bad %0b", o_data, o_bad_index);
            end else begin
                e = reply_q.pop_front();
                if (o_data !== e.data || o_bad_index !== e.bad) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: data exp %0d got %0d, bad exp %0b got %0b",
                                 e.data, o_data, e.bad, o_bad_index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            wd_count <= 0;
        end else if (wd_count >= WD_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    initial begin
        t_dir_row dir [N_DIR];
        t_word    w;
        t_reply   none;
        int       cfg_lr [N_PHASE];
        int       cfg_bu [N_PHASE];
        int       cfg_hu [N_PHASE];

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_op = '0;
        i_index = '0;
        i_value = '0;
        i_feature_a = '0;
        i_feature_b = '0;
        i_target = '0;
        lr = int'(LR_RESET);
        bu_reg = int'(BU_RESET);
        hu_reg = int'(HU_RESET);
        ob = 0;
        foreach (hw[i]) hw[i] = 0;
        foreach (hb[i]) hb[i] = 0;
        foreach (ow[i]) ow[i] = 0;
        foreach (smp_a[i]) begin
            smp_a[i] = 0;
            smp_b[i] = 0;
            smp_t[i] = 0;
        end
        foreach (hid_act[i]) hid_act[i] = 0;
        none.data = '0;
        none.bad  = 1'b0;

        cfg_lr = '{32767, 0, 1, 3277, 0};
        cfg_bu = '{0, 7, 2, 4, 3};
        cfg_hu = '{1, 31, 5, 16, 0};
        cfg_lr[4] = $urandom_range(1, 32766);

        //        op        idx     value     fa        fb        tg       typed  data    bad
        dir[0]  = '{'{OP_WRITE, 7'd0,   16'sh7FFF, 16'sd0, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b0}};
        dir[1]  = '{'{OP_READ,  7'd0,   16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b1, '{16'sh7FFF, 1'b0}};
        dir[2]  = '{'{OP_WRITE, 7'd64,  16'sh8000, 16'sd0, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b0}};
        dir[3]  = '{'{OP_READ,  7'd64,  16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b1, '{16'sh8000, 1'b0}};
        dir[4]  = '{'{OP_WRITE, 7'd65,  16'sh7FFF, 16'sd0, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b1}};
        dir[5]  = '{'{OP_READ,  7'd127, 16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b1, '{16'sd0, 1'b1}};
        dir[6]  = '{'{OP_LOAD,  7'd4,   16'sd0, 16'sd1, 16'sd1, 13'd1},       1'b1, '{16'sd0, 1'b1}};
        dir[7]  = '{'{OP_LOAD,  7'd127, 16'sd0, 16'sd1, 16'sd1, 13'd1},       1'b1, '{16'sd0, 1'b1}};
        dir[8]  = '{'{3'd5,     7'd0,   16'sh7FFF, 16'sd0, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b0}};
        dir[9]  = '{'{3'd6,     7'd127, 16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b1, '{16'sd0, 1'b0}};
        dir[10] = '{'{3'd7,     7'd1,   16'sd0, 16'sh7FFF, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b0}};
        dir[11] = '{'{OP_LOAD,  7'd0,   16'sd0, 16'sh7FFF, 16'sh8000, 13'h1FFF}, 1'b1, '{16'sd0, 1'b0}};
        dir[12] = '{'{OP_LOAD,  7'd1,   16'sd0, 16'sh8000, 16'sh7FFF, 13'd0}, 1'b1, '{16'sd0, 1'b0}};
        dir[13] = '{'{OP_LOAD,  7'd3,   16'sd0, 16'sd4096, 16'sd0, 13'd4096}, 1'b1, '{16'sd0, 1'b0}};
        dir[14] = '{'{OP_TRAIN, 7'd0,   16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b0, none};
        dir[15] = '{'{OP_INFER, 7'd0,   16'sd0, 16'sh7FFF, 16'sh7FFF, 13'd0}, 1'b0, none};
        dir[16] = '{'{OP_INFER, 7'd0,   16'sd0, 16'sh8000, 16'sh8000, 13'd0}, 1'b0, none};
        dir[17] = '{'{OP_INFER, 7'd0,   16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b0, none};
        dir[18] = '{'{OP_WRITE, 7'd31,  16'shFFFF, 16'sd0, 16'sd0, 13'd0},    1'b1, '{16'sd0, 1'b0}};
        dir[19] = '{'{OP_READ,  7'd31,  16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b1, '{-16'sd1, 1'b0}};
        dir[20] = '{'{OP_TRAIN, 7'd127, 16'sd0, 16'sd0, 16'sd0, 13'd0},       1'b0, none};
        dir[21] = '{'{OP_INFER, 7'd0,   16'sd0, 16'sd4096, -16'sd4096, 13'd0}, 1'b0, none};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every parameter and sample slot before anything reads them
        for (int p = 0; p < NPAR; p++) begin
            w = rand_word();
            w.op  = OP_WRITE;
            w.idx = 7'(p);
            send_word(w, 1'b0, none);
        end
        for (int s = 0; s < NBATCH; s++) begin
            w = rand_word();
            w.op  = OP_LOAD;
            w.idx = 7'(s);
            send_word(w, 1'b0, none);
        end

        for (int d = 0; d < N_DIR; d++) send_word(dir[d].w, dir[d].typed, dir[d].r);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            drain();
            cfg_write(CFG_LEARN_RATE, cfg_lr[ph]);
            cfg_write(CFG_BATCH_USED, cfg_bu[ph]);
            cfg_write(CFG_HIDDEN_USED, cfg_hu[ph]);
            i_cfg_we <= 1'b0;
            for (int n = 0; n < PER_PHASE; n++) begin
                // long receiver hold-off while words keep coming
                if (ph == 1 && n == 10) hold_req = 1'b1;
                send_word(rand_word(), 1'b0, none);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
